### hdl/lhfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfm_pkg: shared types and constants for the link health failover monitor
// Window geometry, per-link record, config bundle and priority pick function.
// ----------------------------------------------------------------------------
package lhfm_pkg;

    localparam int WIN_LEN   = 10;
    localparam int NUM_LINKS = 3;
    localparam int LINK_W    = 2;
    localparam int LIMIT_W   = 4;
    localparam int OUT_CNT_W = 4;
    localparam int SLOT_W    = $clog2(WIN_LEN);
    localparam int CNT_W     = $clog2(WIN_LEN + 1);
    localparam int CMP_W     = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
    localparam int APB_AW    = 5;

    localparam logic [CNT_W-1:0]     WIN_LEN_CNT = CNT_W'(WIN_LEN);
    localparam logic [SLOT_W-1:0]    SLOT_LAST   = SLOT_W'(WIN_LEN - 1);
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

    // link codes
    localparam logic [LINK_W-1:0] PORT_NONE     = 2'd3;
    localparam logic [LINK_W-1:0] PORT_FALLBACK = 2'd2;

    // register reset values
    localparam logic [LIMIT_W-1:0] CLOSE_RST  = 4'd3;
    localparam logic [LIMIT_W-1:0] REOPEN_RST = 4'd2;
    localparam logic [LINK_W-1:0]  FIRST_RST  = 2'd0;
    localparam logic [LINK_W-1:0]  SECOND_RST = 2'd1;
    localparam logic [LINK_W-1:0]  THIRD_RST  = 2'd2;
    localparam logic [LINK_W-1:0]  ACTIVE_RST = 2'd0;

    typedef enum logic [2:0] {
        REG_CLOSE  = 3'd0,
        REG_REOPEN = 3'd1,
        REG_FIRST  = 3'd2,
        REG_SECOND = 3'd3,
        REG_THIRD  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] close_lim;
        logic [LIMIT_W-1:0] reopen_lim;
        logic [LINK_W-1:0]  first;
        logic [LINK_W-1:0]  second;
        logic [LINK_W-1:0]  third;
    } cfg_t;

    // per-link state as held in the window memory
    typedef struct packed {
        logic [WIN_LEN-1:0] window;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   succ;
    } link_rec_t;

    localparam link_rec_t REC_RST = '{window: '1, slot: '0, succ: WIN_LEN_CNT};

    typedef struct packed {
        logic              en;
        logic [LINK_W-1:0] addr;
        link_rec_t         data;
    } mem_wr_t;

    function automatic logic entry_good(logic [NUM_LINKS-1:0] good, logic [LINK_W-1:0] p);
        return (p != PORT_NONE) && good[p];
    endfunction

    function automatic logic [LINK_W-1:0] pick_link(logic [NUM_LINKS-1:0] good, cfg_t cfg);
        logic [LINK_W-1:0] sel;
        if (entry_good(good, cfg.first)) begin
            sel = cfg.first;
        end else if (entry_good(good, cfg.second)) begin
            sel = cfg.second;
        end else if (entry_good(good, cfg.third)) begin
            sel = cfg.third;
        end else if (cfg.third != PORT_NONE) begin
            sel = cfg.third;
        end else begin
            sel = PORT_FALLBACK;
        end
        return sel;
    endfunction

endpackage

### hdl/link_health_failover_monitor_core.sv
// An accepted probe fills the read register, its result then the output register.
// Throughput: one probe per cycle while the output is not held full; the window
// memory read plus the single update stage with write-back bypass sets this figure.
// Reset: aresetn synchronous, active low; all links good, active link 0, windows
// full of successes, registers at their reset values.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_failover_monitor_core: three-link probe health monitor
// Sliding success window per link, hysteresis up/down, priority failover.
// ----------------------------------------------------------------------------
module link_health_failover_monitor_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // probe transfer in
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [1:0] probe_port, [2] probe_ok
    // result transfer out
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [1:0] reported_port,
                                                   // [5:2] window_successes,
                                                   // [6] port_up, [8:7] selected_port,
                                                   // [9] selection_changed
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lhfm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    lhfm_pkg::cfg_t              cfg;
    lhfm_pkg::link_rec_t         rd_data;
    lhfm_pkg::mem_wr_t           wr;
    logic                        in_fire;
    logic [lhfm_pkg::LINK_W-1:0] in_port;
    logic                        in_ok;
    logic                        in_keep;

    // A probe on the unused link index is taken and dropped: no record
    // read, no state change, no result transfer.
    assign in_fire = s_tvalid && s_tready;
    assign in_port = s_tdata[1:0];
    assign in_ok   = s_tdata[2];
    assign in_keep = in_fire && (in_port != lhfm_pkg::PORT_NONE);

    lhfm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Record fetch is issued in the accept cycle; a write-back of the same
    // link at that edge is bypassed into the read register.
    lhfm_window_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_keep),
        .rd_addr (in_port),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // Update stage: modify, write back, decide status and failover, and
    // load the output register. Stalls only while the output is full.
    lhfm_health u_health (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .ld_valid (in_keep),
        .ld_port  (in_port),
        .ld_ok    (in_ok),
        .in_ready (s_tready),
        .rd_data  (rd_data),
        .wr       (wr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### hdl/lhfm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfm_cfg: APB configuration registers
// Thresholds and link priority list; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module lhfm_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lhfm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output lhfm_pkg::cfg_t              cfg
);

    lhfm_pkg::cfg_t    cfg_reg;
    logic              wr_en;
    logic [2:0]        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.close_lim  <= lhfm_pkg::CLOSE_RST;
            cfg_reg.reopen_lim <= lhfm_pkg::REOPEN_RST;
            cfg_reg.first      <= lhfm_pkg::FIRST_RST;
            cfg_reg.second     <= lhfm_pkg::SECOND_RST;
            cfg_reg.third      <= lhfm_pkg::THIRD_RST;
        end else if (wr_en) begin
            case (idx)
                lhfm_pkg::REG_CLOSE:  cfg_reg.close_lim  <= pwdata[lhfm_pkg::LIMIT_W-1:0];
                lhfm_pkg::REG_REOPEN: cfg_reg.reopen_lim <= pwdata[lhfm_pkg::LIMIT_W-1:0];
                lhfm_pkg::REG_FIRST:  cfg_reg.first      <= pwdata[lhfm_pkg::LINK_W-1:0];
                lhfm_pkg::REG_SECOND: cfg_reg.second     <= pwdata[lhfm_pkg::LINK_W-1:0];
                lhfm_pkg::REG_THIRD:  cfg_reg.third      <= pwdata[lhfm_pkg::LINK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            lhfm_pkg::REG_CLOSE:  prdata = 32'(cfg_reg.close_lim);
            lhfm_pkg::REG_REOPEN: prdata = 32'(cfg_reg.reopen_lim);
            lhfm_pkg::REG_FIRST:  prdata = 32'(cfg_reg.first);
            lhfm_pkg::REG_SECOND: prdata = 32'(cfg_reg.second);
            lhfm_pkg::REG_THIRD:  prdata = 32'(cfg_reg.third);
            default:              prdata = '0;
        endcase
    end

endmodule

### hdl/lhfm_window_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfm_window_mem: per-link window record store
// One read, one write port; registered read with write-to-read bypass.
// ----------------------------------------------------------------------------
module lhfm_window_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [lhfm_pkg::LINK_W-1:0] rd_addr,
    output lhfm_pkg::link_rec_t         rd_data,
    input  lhfm_pkg::mem_wr_t           wr
);

    lhfm_pkg::link_rec_t           rec_mem_reg [lhfm_pkg::NUM_LINKS];
    logic [lhfm_pkg::NUM_LINKS-1:0] valid_reg;
    lhfm_pkg::link_rec_t           rd_data_reg;

    assign rd_data = rd_data_reg;

    // entries read as reset record until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rec_mem_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && (wr.addr == rd_addr)) begin
                rd_data_reg <= wr.data;
            end else if (valid_reg[rd_addr]) begin
                rd_data_reg <= rec_mem_reg[rd_addr];
            end else begin
                rd_data_reg <= lhfm_pkg::REC_RST;
            end
        end
    end

`ifndef SYNTHESIS
    a_wr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> ($countones(wr.data.window) == int'(wr.data.succ)))
        else $error("window count out of step with window bits");

    a_wr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (wr.addr != lhfm_pkg::PORT_NONE))
        else $error("write to unused link index");
`endif

endmodule

### hdl/lhfm_health.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhfm_health: window update, hysteresis and failover stage
// Modifies the fetched record, writes it back, updates status and output reg.
// ----------------------------------------------------------------------------
module lhfm_health (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lhfm_pkg::cfg_t              cfg,
    input  logic                        ld_valid,
    input  logic [lhfm_pkg::LINK_W-1:0] ld_port,
    input  logic                        ld_ok,
    output logic                        in_ready,
    input  lhfm_pkg::link_rec_t         rd_data,
    output lhfm_pkg::mem_wr_t           wr,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata
);

    logic                                st1_valid_reg;
    logic [lhfm_pkg::LINK_W-1:0]         st1_port_reg;
    logic                                st1_ok_reg;
    logic [lhfm_pkg::NUM_LINKS-1:0]      good_reg;
    logic [lhfm_pkg::NUM_LINKS-1:0]      good_next;
    logic [lhfm_pkg::LINK_W-1:0]         active_reg;
    logic [lhfm_pkg::LINK_W-1:0]         active_next;
    logic                                m_valid_reg;
    logic [15:0]                         m_data_reg;

    logic                                fire;
    logic [lhfm_pkg::SLOT_W-1:0]         slot_cur;
    logic                                old_bit;
    lhfm_pkg::link_rec_t                 rec_new;
    logic [lhfm_pkg::CNT_W-1:0]          fails;
    logic                                good_cur;
    logic                                status_chg;
    logic [lhfm_pkg::OUT_CNT_W-1:0]      succ_out;

    assign fire     = st1_valid_reg && (!m_valid_reg || m_tready);
    assign in_ready = !st1_valid_reg || fire;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        slot_cur = rd_data.slot;
        if (({1'b0, rd_data.slot}) > ({1'b0, lhfm_pkg::SLOT_LAST})) begin
            slot_cur = '0;
        end
        old_bit = rd_data.window[slot_cur];

        rec_new = rd_data;
        rec_new.window[slot_cur] = st1_ok_reg;
        rec_new.slot = (slot_cur == lhfm_pkg::SLOT_LAST) ? '0 : slot_cur + 1'b1;
        rec_new.succ = rd_data.succ - lhfm_pkg::CNT_W'(old_bit)
                     + lhfm_pkg::CNT_W'(st1_ok_reg);

        fails    = lhfm_pkg::WIN_LEN_CNT - rec_new.succ;
        good_cur = good_reg[st1_port_reg];
        // close test only for a good link, reopen test only for a down link
        if (good_cur) begin
            status_chg = lhfm_pkg::CMP_W'(fails) >= lhfm_pkg::CMP_W'(cfg.close_lim);
        end else begin
            status_chg = lhfm_pkg::CMP_W'(fails) <= lhfm_pkg::CMP_W'(cfg.reopen_lim);
        end

        good_next = good_reg;
        if (status_chg) begin
            good_next[st1_port_reg] = !good_cur;
        end
        active_next = status_chg ? lhfm_pkg::pick_link(good_next, cfg) : active_reg;

        if (lhfm_pkg::CMP_W'(rec_new.succ) > lhfm_pkg::CMP_W'(lhfm_pkg::OUT_CNT_MAX)) begin
            succ_out = lhfm_pkg::OUT_CNT_MAX;
        end else begin
            succ_out = lhfm_pkg::OUT_CNT_W'(rec_new.succ);
        end

        wr.en   = fire;
        wr.addr = st1_port_reg;
        wr.data = rec_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            good_reg      <= '1;
            active_reg    <= lhfm_pkg::ACTIVE_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            if (ld_valid) begin
                st1_valid_reg <= 1'b1;
            end else if (fire) begin
                st1_valid_reg <= 1'b0;
            end
            if (fire) begin
                good_reg    <= good_next;
                active_reg  <= active_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_valid) begin
            st1_port_reg <= ld_port;
            st1_ok_reg   <= ld_ok;
        end
        if (fire) begin
            m_data_reg <= {6'b0, (active_next != active_reg), active_next,
                           good_next[st1_port_reg], succ_out, st1_port_reg};
        end
    end

`ifndef SYNTHESIS
    a_active_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg != lhfm_pkg::PORT_NONE)
        else $error("active link holds unused index");

    a_no_change_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !status_chg) |=> (active_reg == $past(active_reg) && !m_data_reg[9]))
        else $error("active link moved without a status change");
`endif

endmodule

### sim/tb_link_health_failover_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_link_health_failover_monitor_core: self-checking bench for the monitor
// Drives probe transfers and register writes, predicts every result transfer
// from a behavioral copy of the window, hysteresis and failover logic, and
// checks the results in order under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_link_health_failover_monitor_core;

    // one result transfer, unpacked
    typedef struct {
        logic [lhfm_pkg::LINK_W-1:0]    port;
        logic [lhfm_pkg::OUT_CNT_W-1:0] successes;
        logic                           up;
        logic [lhfm_pkg::LINK_W-1:0]    selected;
        logic                           changed;
    } link_report_t;

    // Behavioral copy of the monitor plus the queue of reports it predicts.
    class link_health_tracker;
        lhfm_pkg::cfg_t               cfg;
        logic [lhfm_pkg::WIN_LEN-1:0] window [lhfm_pkg::NUM_LINKS];
        int                           slot [lhfm_pkg::NUM_LINKS];
        int                           succ [lhfm_pkg::NUM_LINKS];
        logic                         good [lhfm_pkg::NUM_LINKS];
        logic [lhfm_pkg::LINK_W-1:0]  active;
        link_report_t                 expected_reports [$];
        int                           mismatch_count;

        function new();
            cfg.close_lim  = lhfm_pkg::CLOSE_RST;
            cfg.reopen_lim = lhfm_pkg::REOPEN_RST;
            cfg.first      = lhfm_pkg::FIRST_RST;
            cfg.second     = lhfm_pkg::SECOND_RST;
            cfg.third      = lhfm_pkg::THIRD_RST;
            for (int i = 0; i < lhfm_pkg::NUM_LINKS; i++) begin
                window[i] = '1;
                slot[i]   = 0;
                succ[i]   = lhfm_pkg::WIN_LEN;
                good[i]   = 1'b1;
            end
            active         = lhfm_pkg::ACTIVE_RST;
            mismatch_count = 0;
        endfunction

        function void set_reg(lhfm_pkg::reg_idx_t idx, logic [31:0] value);
            case (idx)
                lhfm_pkg::REG_CLOSE:  cfg.close_lim  = value[lhfm_pkg::LIMIT_W-1:0];
                lhfm_pkg::REG_REOPEN: cfg.reopen_lim = value[lhfm_pkg::LIMIT_W-1:0];
                lhfm_pkg::REG_FIRST:  cfg.first      = value[lhfm_pkg::LINK_W-1:0];
                lhfm_pkg::REG_SECOND: cfg.second     = value[lhfm_pkg::LINK_W-1:0];
                lhfm_pkg::REG_THIRD:  cfg.third      = value[lhfm_pkg::LINK_W-1:0];
                default: ;
            endcase
        endfunction

        // first good entry in priority order, else the third entry if used, else link 2; link 3 never counts as good
        function logic [lhfm_pkg::LINK_W-1:0] choose_link();
            logic [lhfm_pkg::LINK_W-1:0] order [3];
            order[0] = cfg.first;
            order[1] = cfg.second;
            order[2] = cfg.third;
            foreach (order[k]) begin
                if (order[k] != lhfm_pkg::PORT_NONE && good[order[k]]) begin
                    return order[k];
                end
            end
            return (cfg.third != lhfm_pkg::PORT_NONE) ? cfg.third : lhfm_pkg::PORT_FALLBACK;
        endfunction

        function void note_probe(logic [1:0] port, logic ok);
            link_report_t                r;
            int                          fails;
            logic                        flipped;
            logic [lhfm_pkg::LINK_W-1:0] prev;
            if (port == lhfm_pkg::PORT_NONE) begin
                return;                     // ignored, no result
            end
            if (window[port][slot[port]]) begin
                succ[port]--;
            end
            window[port][slot[port]] = ok;
            if (ok) begin
                succ[port]++;
            end
            slot[port] = (slot[port] == lhfm_pkg::WIN_LEN - 1) ? 0 : slot[port] + 1;

            fails   = lhfm_pkg::WIN_LEN - succ[port];
            flipped = 1'b0;
            if (good[port] && fails >= int'(cfg.close_lim)) begin
                good[port] = 1'b0;
                flipped    = 1'b1;
            end else if (!good[port] && fails <= int'(cfg.reopen_lim)) begin
                good[port] = 1'b1;
                flipped    = 1'b1;
            end
            prev = active;
            if (flipped) begin
                active = choose_link();
            end

            r.port      = port;
            r.successes = (succ[port] > 15) ? lhfm_pkg::OUT_CNT_MAX
                                            : lhfm_pkg::OUT_CNT_W'(succ[port]);
            r.up        = good[port];
            r.selected  = active;
            r.changed   = (active != prev);
            expected_reports.push_back(r);
        endfunction

        task flag_mismatch(string what, int got, int want);
            mismatch_count++;
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task check_result(logic [15:0] data);
            link_report_t e;
            if (expected_reports.size() == 0) begin
                flag_mismatch("unexpected result transfer", int'(data), -1);
                return;
            end
            e = expected_reports.pop_front();
            if (data[1:0] !== e.port)      flag_mismatch("reported_port", data[1:0], e.port);
            if (data[5:2] !== e.successes) flag_mismatch("window_successes", data[5:2],
                                                         e.successes);
            if (data[6] !== e.up)          flag_mismatch("port_up", data[6], e.up);
            if (data[8:7] !== e.selected)  flag_mismatch("selected_port", data[8:7], e.selected);
            if (data[9] !== e.changed)     flag_mismatch("selection_changed", data[9],
                                                         e.changed);
        endtask
    endclass

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = '0;     // [1:0] probe_port, [2] probe_ok
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [15:0]                 m_tdata;           // [1:0] reported_port,
                                                    // [5:2] window_successes,
                                                    // [6] port_up, [8:7] selected_port,
                                                    // [9] selection_changed
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [lhfm_pkg::APB_AW-1:0] paddr    = '0;
    logic [31:0]                 pwdata   = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    link_health_tracker tracker;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    link_health_failover_monitor_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check accepted transfers, then pick next cycle's tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one probe transfer; tvalid only drops while the sender idles
    task automatic send_probe(input logic [1:0] port, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, ok, port};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_probe(port, ok);
    endtask

    // stop sending and let every expected result arrive, then idle before returning
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // setup phase, access phase, then the bus returns to idle
    task automatic write_reg(input lhfm_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lhfm_pkg::APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        tracker.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input int close_l, input int reopen_l,
                               input int first_p, input int second_p, input int third_p);
        write_reg(lhfm_pkg::REG_CLOSE, close_l);
        write_reg(lhfm_pkg::REG_REOPEN, reopen_l);
        write_reg(lhfm_pkg::REG_FIRST, first_p);
        write_reg(lhfm_pkg::REG_SECOND, second_p);
        write_reg(lhfm_pkg::REG_THIRD, third_p);
        @(posedge aclk);
    endtask

    task automatic repeat_probe(input logic [1:0] port, input logic ok, input int count);
        repeat (count) send_probe(port, ok);
    endtask

    // bursts on one link with a biased success rate push links through
    // both thresholds; a few link-3 probes are mixed in as noise
    task automatic random_probes(input int n_items);
        int          sent;
        int          run_len;
        int          ok_pct;
        logic [1:0]  port;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 4) begin
                send_probe(lhfm_pkg::PORT_NONE, $urandom_range(1));
                continue;
            end
            port    = $urandom_range(lhfm_pkg::NUM_LINKS - 1);
            run_len = $urandom_range(1, 12);
            case ($urandom_range(2))
                0:       ok_pct = 10;
                1:       ok_pct = 50;
                default: ok_pct = 92;
            endcase
            repeat (run_len) begin
                send_probe(port, $urandom_range(99) < ok_pct);
                sent++;
            end
        end
    endtask

    // per-phase register settings: close, reopen, first, second, third
    int phase_cfg [9][5] = '{
        '{3,  2,  0, 1, 2},
        '{0,  0,  2, 1, 0},   // close at zero: any probe takes a good link down
        '{10, 10, 1, 0, 2},
        '{5,  1,  3, 2, 1},   // top priority entry unused
        '{4,  0,  3, 3, 3},   // no usable entry: fallback to link 2
        '{2,  6,  2, 0, 1},   // crossed limits: links toggle
        '{15, 15, 1, 2, 0},   // never closes, reopens at once
        '{1,  0,  0, 2, 3},
        '{7,  3,  2, 1, 0}
    };

    initial begin
        tracker = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_probe(lhfm_pkg::PORT_NONE, 1'b1);      // link 3 is ignored
        send_probe(lhfm_pkg::PORT_NONE, 1'b0);
        repeat_probe(2'd0, 1'b0, 3);      // link 0 down, failover to 1
        repeat_probe(2'd1, 1'b0, 3);      // link 1 down, failover to 2
        repeat_probe(2'd2, 1'b0, 3);      // all down, fallback keeps 2
        repeat_probe(2'd2, 1'b1, 8);      // window rolls over, link 2 reopens
        send_probe(2'd1, 1'b1);
        send_probe(2'd0, 1'b1);
        wait_quiet();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            load_config(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2],
                        phase_cfg[ph][3], phase_cfg[ph][4]);
            random_probes(210);
            wait_quiet();
        end

        repeat (10) @(posedge aclk);
        if (tracker.mismatch_count == 0 && tracker.expected_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
